### rtl/hsswr_pkg.sv
// Package: shared types, codes and reset values for the single-wire sensor reader.
`timescale 1ns / 1ps
package hsswr_pkg;

  localparam int FRAME_BITS_DEF = 41;
  localparam int FRAME_W        = 40;
  localparam int RETRY_W        = 10;
  localparam int MS_W           = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int HUM_W          = 15;
  localparam int TEMP_W         = 16;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_MS     = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_QUICK = 3'd1;
  localparam logic [2:0] ST_BUS_HUNG  = 3'd2;
  localparam logic [2:0] ST_ABSENT    = 3'd3;
  localparam logic [2:0] ST_ACK_LONG  = 3'd4;
  localparam logic [2:0] ST_SYNC      = 3'd5;
  localparam logic [2:0] ST_DATA_TO   = 3'd6;
  localparam logic [2:0] ST_CHECKSUM  = 3'd7;

  localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
  localparam logic [2:0] REG_START_PULSE  = 3'd1;
  localparam logic [2:0] REG_BIT_THRESH   = 3'd2;
  localparam logic [2:0] REG_IDLE_HIGH    = 3'd3;
  localparam logic [2:0] REG_ACK_START    = 3'd4;
  localparam logic [2:0] REG_ACK_END      = 3'd5;
  localparam logic [2:0] REG_SYNC         = 3'd6;
  localparam logic [2:0] REG_BIT_HIGH     = 3'd7;

  localparam logic [15:0] RST_MIN_INTERVAL = 16'd2000;
  localparam logic [9:0]  RST_START_PULSE  = 10'd550;
  localparam logic [7:0]  RST_BIT_THRESH   = 8'd11;
  localparam logic [7:0]  RST_IDLE_HIGH    = 8'd125;
  localparam logic [7:0]  RST_ACK_START    = 8'd25;
  localparam logic [7:0]  RST_ACK_END      = 8'd50;
  localparam logic [7:0]  RST_SYNC         = 8'd35;
  localparam logic [7:0]  RST_BIT_HIGH     = 8'd50;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_HIGH = 3'd1,
    PH_PULSE     = 3'd2,
    PH_ACK_START = 3'd3,
    PH_ACK_END   = 3'd4,
    PH_SYNC      = 3'd5,
    PH_BIT_HIGH  = 3'd6
  } phase_t;

  typedef struct packed {
    logic                     csum_ok;
    logic [HUM_W-1:0]         humidity;
    logic signed [TEMP_W-1:0] temperature;
  } frame_dec_t;

endpackage

### rtl/humidity_sensor_single_wire_reader.sv
// Top level: single-wire humidity and temperature sensor reader.
// Each input item (sample tick, millisecond tick or start request) yields exactly one
// registered result in the cycle after its transfer; while in_stall is low a new item is
// taken every cycle. The only limit on rate is the single output register: while a result
// waits under out_stall, in_stall is raised. A read runs as a phase sequencer stepped by
// sample ticks with a retry counter per phase; after FRAME_BITS data bits the last 40 form
// the frame, decoded with checksum on the item that ends the read.
`timescale 1ns / 1ps
module humidity_sensor_single_wire_reader #(
  parameter int FRAME_BITS = hsswr_pkg::FRAME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_action,
  input  logic                                 in_line_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_drive_low,
  output logic                                 out_busy_res,
  output logic                                 out_done_res,
  output logic [2:0]                           out_status,
  output logic [hsswr_pkg::HUM_W-1:0]          out_humidity,
  output logic signed [hsswr_pkg::TEMP_W-1:0]  out_temperature,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hsswr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsswr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hsswr_pkg::*;

  localparam int BIT_W = $clog2(FRAME_BITS + 1);

  logic [15:0] min_interval_r;
  logic [9:0]  start_pulse_r;
  logic [7:0]  bit_thresh_r;
  logic [7:0]  idle_high_r;
  logic [7:0]  ack_start_r;
  logic [7:0]  ack_end_r;
  logic [7:0]  sync_lim_r;
  logic [7:0]  bit_high_r;

  phase_t             phase_r, phase_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt, retry_inc;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [MS_W-1:0]    ms_r, ms_nxt;

  logic               bit_val;
  logic [FRAME_W-1:0] frame_shift;

  logic               done_nxt;
  logic [2:0]         status_nxt;
  logic               use_frame;
  frame_dec_t         dec;

  logic                     out_valid_r;
  logic                     drive_low_r, drive_low_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r;
  logic [2:0]               status_r;
  logic [HUM_W-1:0]         hum_r, hum_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;

  logic accept;

  assign in_stall    = out_valid_r & out_stall;
  assign accept      = in_valid & ~in_stall;
  assign cfg_ready   = 1'b1;
  assign retry_inc   = retry_r + RETRY_W'(1);
  assign bit_val     = (retry_inc > {2'b00, bit_thresh_r});
  assign frame_shift = {frame_r[FRAME_W-2:0], bit_val};

  hsswr_frame_decode u_decode (
    .frame (frame_shift),
    .dec   (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= RST_MIN_INTERVAL;
      start_pulse_r  <= RST_START_PULSE;
      bit_thresh_r   <= RST_BIT_THRESH;
      idle_high_r    <= RST_IDLE_HIGH;
      ack_start_r    <= RST_ACK_START;
      ack_end_r      <= RST_ACK_END;
      sync_lim_r     <= RST_SYNC;
      bit_high_r     <= RST_BIT_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_INTERVAL: min_interval_r <= cfg_data;
        REG_START_PULSE:  start_pulse_r  <= cfg_data[9:0];
        REG_BIT_THRESH:   bit_thresh_r   <= cfg_data[7:0];
        REG_IDLE_HIGH:    idle_high_r    <= cfg_data[7:0];
        REG_ACK_START:    ack_start_r    <= cfg_data[7:0];
        REG_ACK_END:      ack_end_r      <= cfg_data[7:0];
        REG_SYNC:         sync_lim_r     <= cfg_data[7:0];
        REG_BIT_HIGH:     bit_high_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next state for one item
  always_comb begin
    phase_nxt  = phase_r;
    retry_nxt  = retry_r;
    bit_nxt    = bit_r;
    frame_nxt  = frame_r;
    ms_nxt     = ms_r;
    done_nxt   = 1'b0;
    status_nxt = ST_OK;
    use_frame  = 1'b0;
    if (in_action == ACT_MS) begin
      if (ms_r != {MS_W{1'b1}}) begin
        ms_nxt = ms_r + MS_W'(1);
      end
    end else if (in_action == ACT_START) begin
      if (phase_r == PH_IDLE) begin
        if (ms_r < min_interval_r) begin
          done_nxt   = 1'b1;
          status_nxt = ST_TOO_QUICK;
          retry_nxt  = '0;
        end else begin
          ms_nxt    = '0;
          phase_nxt = PH_WAIT_HIGH;
          retry_nxt = '0;
          bit_nxt   = '0;
          frame_nxt = '0;
        end
      end
    end else if (in_action == ACT_SAMPLE && phase_r != PH_IDLE) begin
      retry_nxt = retry_inc;
      unique case (phase_r)
        PH_WAIT_HIGH: begin
          if (in_line_level) begin
            phase_nxt = PH_PULSE;
            retry_nxt = '0;
          end else if (retry_inc > {2'b00, idle_high_r}) begin
            done_nxt   = 1'b1;
            status_nxt = ST_BUS_HUNG;
          end
        end
        PH_PULSE: begin
          if (retry_inc >= start_pulse_r) begin
            phase_nxt = PH_ACK_START;
            retry_nxt = '0;
          end
        end
        PH_ACK_START: begin
          if (in_line_level) begin
            phase_nxt = PH_ACK_END;
            retry_nxt = '0;
          end else if (retry_inc > {2'b00, ack_start_r}) begin
            done_nxt   = 1'b1;
            status_nxt = ST_ABSENT;
          end
        end
        PH_ACK_END: begin
          if (!in_line_level) begin
            phase_nxt = PH_SYNC;
            retry_nxt = '0;
          end else if (retry_inc > {2'b00, ack_end_r}) begin
            done_nxt   = 1'b1;
            status_nxt = ST_ACK_LONG;
          end
        end
        PH_SYNC: begin
          if (in_line_level) begin
            phase_nxt = PH_BIT_HIGH;
            retry_nxt = '0;
          end else if (retry_inc > {2'b00, sync_lim_r}) begin
            done_nxt   = 1'b1;
            status_nxt = ST_SYNC;
          end
        end
        PH_BIT_HIGH: begin
          if (!in_line_level) begin
            frame_nxt = frame_shift;
            bit_nxt   = bit_r + BIT_W'(1);
            retry_nxt = '0;
            if (bit_nxt >= BIT_W'(FRAME_BITS)) begin
              done_nxt   = 1'b1;
              use_frame  = 1'b1;
              status_nxt = dec.csum_ok ? ST_OK : ST_CHECKSUM;
            end else begin
              phase_nxt = PH_SYNC;
            end
          end else if (retry_inc > {2'b00, bit_high_r}) begin
            done_nxt   = 1'b1;
            status_nxt = ST_DATA_TO;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          retry_nxt = '0;
        end
      endcase
      if (done_nxt) begin
        phase_nxt = PH_IDLE;
        retry_nxt = '0;
      end
    end
  end

  // Result fields
  always_comb begin
    drive_low_nxt = (phase_nxt == PH_PULSE);
    busy_nxt      = (phase_nxt != PH_IDLE);
    hum_nxt       = use_frame ? dec.humidity : '0;
    temp_nxt      = use_frame ? dec.temperature : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      retry_r     <= '0;
      bit_r       <= '0;
      frame_r     <= '0;
      ms_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        retry_r <= retry_nxt;
        bit_r   <= bit_nxt;
        frame_r <= frame_nxt;
        ms_r    <= ms_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_low_r <= drive_low_nxt;
      busy_r      <= busy_nxt;
      done_r      <= done_nxt;
      status_r    <= status_nxt;
      hum_r       <= hum_nxt;
      temp_r      <= temp_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_low   = drive_low_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_status      = status_r;
  assign out_humidity    = hum_r;
  assign out_temperature = temp_r;

endmodule

### rtl/hsswr_frame_decode.sv
// Frame decode: checksum check, humidity and sign-magnitude temperature.
`timescale 1ns / 1ps
module hsswr_frame_decode (
  input  logic [hsswr_pkg::FRAME_W-1:0] frame,
  output hsswr_pkg::frame_dec_t         dec
);
  import hsswr_pkg::*;

  logic [15:0] hraw;
  logic [15:0] traw;
  logic [7:0]  csum;
  logic [7:0]  sum;

  assign hraw = frame[39:24];
  assign traw = frame[23:8];
  assign csum = frame[7:0];
  assign sum  = hraw[15:8] + hraw[7:0] + traw[15:8] + traw[7:0];

  always_comb begin
    dec.csum_ok  = (sum == csum);
    dec.humidity = hraw[HUM_W-1:0];
    if (traw[15]) begin
      dec.temperature = -$signed({1'b0, traw[14:0]});
    end else begin
      dec.temperature = $signed(traw);
    end
  end

endmodule

### bench/tb.sv
// Self-checking bench for the single-wire humidity sensor reader: predictor, stimulus, scoreboard.
`timescale 1ns / 1ps
module tb;
  import hsswr_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic               drive_low;
    logic               busy;
    logic               done;
    logic [2:0]         status;
    logic [HUM_W-1:0]   humidity;
    logic signed [15:0] temperature;
  } sensor_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_action;
  logic in_line_level;
  logic out_valid;
  logic out_stall;
  logic out_drive_low;
  logic out_busy_res;
  logic out_done_res;
  logic [2:0] out_status;
  logic [HUM_W-1:0] out_humidity;
  logic signed [TEMP_W-1:0] out_temperature;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  humidity_sensor_single_wire_reader dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_line_level(in_line_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_drive_low(out_drive_low), .out_busy_res(out_busy_res),
    .out_done_res(out_done_res), .out_status(out_status),
    .out_humidity(out_humidity), .out_temperature(out_temperature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register mirror
  logic [15:0] min_ms_set;
  logic [9:0]  pulse_set;
  logic [7:0]  thresh_set;
  logic [7:0]  idle_lim;
  logic [7:0]  ack_start_lim;
  logic [7:0]  ack_end_lim;
  logic [7:0]  sync_lim;
  logic [7:0]  bit_high_lim;

  // read sequencer mirror
  phase_t      rd_phase;
  logic [9:0]  rd_retry;
  logic [5:0]  rd_bits_seen;
  logic [39:0] rd_frame;
  logic [15:0] ms_elapsed;

  sensor_res_t pending_results[$];
  int mismatch_cnt;
  int n_sent;
  int cycle_cnt;
  int idle_max;
  int stall_max;
  int stall_left;
  int long_hold;
  bit noise_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic sensor_res_t sensor_step(input logic [1:0] act, input logic lvl);
    sensor_res_t r;
    logic [2:0] st;
    logic ended;
    logic [15:0] hraw;
    logic [15:0] traw;
    logic [7:0] sum;
    r = '0;
    st = ST_OK;
    ended = 1'b0;
    if (act == ACT_MS) begin
      if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
    end else if (act == ACT_START) begin
      if (rd_phase == PH_IDLE) begin
        if (ms_elapsed < min_ms_set) begin
          ended = 1'b1;
          st = ST_TOO_QUICK;
        end else begin
          ms_elapsed = '0;
          rd_phase = PH_WAIT_HIGH;
          rd_retry = '0;
          rd_bits_seen = '0;
          rd_frame = '0;
        end
      end
    end else if (act == ACT_SAMPLE && rd_phase != PH_IDLE) begin
      rd_retry = rd_retry + 10'd1;
      case (rd_phase)
        PH_WAIT_HIGH: begin
          if (lvl) begin
            rd_phase = PH_PULSE;
            rd_retry = '0;
          end else if (rd_retry > idle_lim) begin
            ended = 1'b1;
            st = ST_BUS_HUNG;
          end
        end
        PH_PULSE: begin
          if (rd_retry >= pulse_set) begin
            rd_phase = PH_ACK_START;
            rd_retry = '0;
          end
        end
        PH_ACK_START: begin
          if (lvl) begin
            rd_phase = PH_ACK_END;
            rd_retry = '0;
          end else if (rd_retry > ack_start_lim) begin
            ended = 1'b1;
            st = ST_ABSENT;
          end
        end
        PH_ACK_END: begin
          if (!lvl) begin
            rd_phase = PH_SYNC;
            rd_retry = '0;
          end else if (rd_retry > ack_end_lim) begin
            ended = 1'b1;
            st = ST_ACK_LONG;
          end
        end
        PH_SYNC: begin
          if (lvl) begin
            rd_phase = PH_BIT_HIGH;
            rd_retry = '0;
          end else if (rd_retry > sync_lim) begin
            ended = 1'b1;
            st = ST_SYNC;
          end
        end
        PH_BIT_HIGH: begin
          if (!lvl) begin
            rd_frame = {rd_frame[38:0], rd_retry > thresh_set};
            rd_bits_seen = rd_bits_seen + 6'd1;
            rd_retry = '0;
            if (rd_bits_seen >= FRAME_BITS_DEF) begin
              ended = 1'b1;
              hraw = rd_frame[39:24];
              traw = rd_frame[23:8];
              sum = hraw[15:8] + hraw[7:0] + traw[15:8] + traw[7:0];
              st = (sum == rd_frame[7:0]) ? ST_OK : ST_CHECKSUM;
              r.humidity = hraw[14:0];
              // sign-magnitude to two's complement
              if (traw[15]) r.temperature = -$signed({1'b0, traw[14:0]});
              else r.temperature = traw;
            end else begin
              rd_phase = PH_SYNC;
            end
          end else if (rd_retry > bit_high_lim) begin
            ended = 1'b1;
            st = ST_DATA_TO;
          end
        end
        default: begin
          rd_phase = PH_IDLE;
          rd_retry = '0;
        end
      endcase
    end
    if (ended) begin
      rd_phase = PH_IDLE;
      rd_retry = '0;
    end
    r.drive_low = (rd_phase == PH_PULSE);
    r.busy = (rd_phase != PH_IDLE);
    r.done = ended;
    r.status = st;
    return r;
  endfunction

  function automatic void mirror_reg(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      REG_MIN_INTERVAL: min_ms_set = v;
      REG_START_PULSE:  pulse_set = v[9:0];
      REG_BIT_THRESH:   thresh_set = v[7:0];
      REG_IDLE_HIGH:    idle_lim = v[7:0];
      REG_ACK_START:    ack_start_lim = v[7:0];
      REG_ACK_END:      ack_end_lim = v[7:0];
      REG_SYNC:         sync_lim = v[7:0];
      REG_BIT_HIGH:     bit_high_lim = v[7:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // result scoreboard
  always @(posedge clk) begin
    sensor_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("drive_low", 32'(want.drive_low), 32'(out_drive_low));
        check_field("busy_res", 32'(want.busy), 32'(out_busy_res));
        check_field("done_res", 32'(want.done), 32'(out_done_res));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("humidity", 32'(want.humidity), 32'(out_humidity));
        check_field("temperature", 32'(want.temperature), 32'(out_temperature));
      end
      stall_left = $urandom_range(0, stall_max);
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic lvl);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_line_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(sensor_step(act, lvl));
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input int min_ms, input int pulse, input int thr, input int idle_l,
                           input int acks_l, input int acke_l, input int sync_l,
                           input int bith_l);
    wait_drained();
    write_reg(REG_MIN_INTERVAL, 16'(min_ms));
    write_reg(REG_START_PULSE, 16'(pulse));
    write_reg(REG_BIT_THRESH, 16'(thr));
    write_reg(REG_IDLE_HIGH, 16'(idle_l));
    write_reg(REG_ACK_START, 16'(acks_l));
    write_reg(REG_ACK_END, 16'(acke_l));
    write_reg(REG_SYNC, 16'(sync_l));
    write_reg(REG_BIT_HIGH, 16'(bith_l));
  endtask

  // short timings so frames stay cheap
  task automatic write_small();
    int thr;
    thr = $urandom_range(1, 4);
    write_all($urandom_range(0, 3), $urandom_range(0, 4), thr, $urandom_range(0, 6),
              $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
              thr + $urandom_range(2, 6));
  endtask

  task automatic tick(input logic lvl);
    logic [1:0] extra;
    if (noise_on && $urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0: extra = ACT_MS;
        1: extra = ACT_START;
        default: extra = ACT_NONE;
      endcase
      send_item(extra, 1'($urandom));
    end
    send_item(ACT_SAMPLE, lvl);
  endtask

  task automatic ticks(input int n, input logic lvl);
    repeat (n) tick(lvl);
  endtask

  function automatic int pick_wait(input int lim);
    if ($urandom_range(0, 7) == 0) return lim;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, (lim < 3) ? lim : 3);
  endfunction

  function automatic logic [39:0] make_frame(input logic [15:0] hum, input logic [15:0] temp,
                                             input bit good);
    logic [7:0] sum;
    sum = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
    if (!good) sum = sum ^ 8'($urandom_range(1, 255));
    return {hum, temp, sum};
  endfunction

  // one sensor transaction; brk names the phase that is held past its limit
  task automatic read_frame(input logic [39:0] frame, input logic [2:0] brk);
    logic [FRAME_BITS_DEF-1:0] bits;
    int brk_bit;
    int h;
    int lim0;
    bits = FRAME_BITS_DEF'({$urandom, $urandom});
    bits[39:0] = frame;
    brk_bit = $urandom_range(0, FRAME_BITS_DEF - 1);
    repeat (min_ms_set) send_item(ACT_MS, 1'($urandom));
    send_item(ACT_START, 1'($urandom));
    if (brk == ST_BUS_HUNG) begin
      ticks(idle_lim + 1, 1'b0);
      return;
    end
    ticks(pick_wait(int'(idle_lim)), 1'b0);
    tick(1'b1);
    repeat ((pulse_set == 0) ? 1 : pulse_set) tick(1'($urandom));
    if (brk == ST_ABSENT) begin
      ticks(ack_start_lim + 1, 1'b0);
      return;
    end
    ticks(pick_wait(int'(ack_start_lim)), 1'b0);
    tick(1'b1);
    if (brk == ST_ACK_LONG) begin
      ticks(ack_end_lim + 1, 1'b1);
      return;
    end
    ticks(pick_wait(int'(ack_end_lim)), 1'b1);
    tick(1'b0);
    for (int i = FRAME_BITS_DEF - 1; i >= 0; i--) begin
      if (brk == ST_SYNC && i == brk_bit) begin
        ticks(sync_lim + 1, 1'b0);
        return;
      end
      ticks(pick_wait(int'(sync_lim)), 1'b0);
      tick(1'b1);
      if (brk == ST_DATA_TO && i == brk_bit) begin
        ticks(bit_high_lim + 1, 1'b1);
        return;
      end
      lim0 = (thresh_set < 4) ? int'(thresh_set) - 1 : 3;
      if (bits[i]) h = thresh_set + $urandom_range(0, 2);
      else h = (thresh_set == 0) ? 0 : $urandom_range(0, lim0);
      if (h > bit_high_lim) h = int'(bit_high_lim);
      ticks(h, 1'b1);
      tick(1'b0);
    end
  endtask

  task automatic test_idle_items();
    send_item(ACT_NONE, 1'b0);
    send_item(ACT_NONE, 1'b1);
    send_item(ACT_SAMPLE, 1'b0);
    send_item(ACT_SAMPLE, 1'b1);
    send_item(ACT_MS, 1'b1);
    send_item(ACT_START, 1'b0);
    send_item(ACT_MS, 1'b0);
    send_item(ACT_START, 1'b1);
  endtask

  task automatic test_reset_defaults();
    repeat (5) send_item(ACT_MS, 1'($urandom));
    send_item(ACT_START, 1'b1);
    send_item(ACT_SAMPLE, 1'b1);
  endtask

  task automatic test_frames();
    write_all(0, 1, 1, 0, 0, 0, 0, 3);
    read_frame(make_frame(16'h03E8, 16'h80C8, 1'b1), ST_OK);
    read_frame(make_frame(16'($urandom), 16'($urandom), 1'b0), ST_OK);
  endtask

  task automatic test_too_quick();
    wait_drained();
    write_reg(REG_MIN_INTERVAL, 16'd3);
    read_frame('0, ST_ABSENT);
    send_item(ACT_START, 1'b1);
    send_item(ACT_MS, 1'b0);
    send_item(ACT_MS, 1'b1);
    send_item(ACT_START, 1'b0);
    send_item(ACT_MS, 1'b0);
    send_item(ACT_START, 1'b0);
    // start while busy is ignored
    send_item(ACT_START, 1'b1);
    ticks(3, 1'b0);
  endtask

  task automatic test_phase_errors();
    write_small();
    read_frame('0, ST_BUS_HUNG);
    read_frame('0, ST_ABSENT);
    read_frame('0, ST_ACK_LONG);
    read_frame(40'($urandom), ST_SYNC);
    read_frame(40'($urandom), ST_DATA_TO);
  endtask

  task automatic test_register_extremes();
    write_all(0, 1, 0, 0, 0, 0, 0, 0);
    read_frame('0, ST_ABSENT);
    read_frame('0, ST_DATA_TO);
    wait_drained();
    write_reg(REG_START_PULSE, 16'd0);
    read_frame('0, ST_ABSENT);
  endtask

  task automatic test_backpressure();
    idle_max = 0;
    long_hold = 120;
    read_frame({40{1'b1}}, ST_OK);
    idle_max = 6;
    repeat (10) send_item(ACT_MS, 1'($urandom));
    wait_drained();
  endtask

  task automatic test_random();
    int stop_at;
    int scen;
    int sel;
    logic [2:0] codes [5];
    codes = '{ST_BUS_HUNG, ST_ABSENT, ST_ACK_LONG, ST_SYNC, ST_DATA_TO};
    stop_at = n_sent + 150;
    scen = 0;
    noise_on = 1'b1;
    while (n_sent < stop_at) begin
      if (scen % 4 == 0) begin
        write_small();
        idle_max = $urandom_range(0, 1) * 6;
        stall_max = $urandom_range(0, 1) * 6;
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        read_frame(make_frame(16'($urandom), 16'($urandom), $urandom_range(0, 3) != 0), ST_OK);
      end else if (sel < 9) begin
        read_frame(40'({$urandom, $urandom}), codes[$urandom_range(0, 4)]);
      end else begin
        repeat ($urandom_range(5, 20)) send_item(2'($urandom), 1'($urandom));
      end
      scen++;
    end
    noise_on = 1'b0;
    idle_max = 6;
    stall_max = 6;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_SAMPLE;
    in_line_level = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_INTERVAL;
    cfg_data = '0;
    mismatch_cnt = 0;
    n_sent = 0;
    cycle_cnt = 0;
    idle_max = 6;
    stall_max = 6;
    stall_left = 0;
    long_hold = 0;
    noise_on = 1'b0;
    min_ms_set = RST_MIN_INTERVAL;
    pulse_set = RST_START_PULSE;
    thresh_set = RST_BIT_THRESH;
    idle_lim = RST_IDLE_HIGH;
    ack_start_lim = RST_ACK_START;
    ack_end_lim = RST_ACK_END;
    sync_lim = RST_SYNC;
    bit_high_lim = RST_BIT_HIGH;
    rd_phase = PH_IDLE;
    rd_retry = '0;
    rd_bits_seen = '0;
    rd_frame = '0;
    ms_elapsed = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_reset_defaults();
    test_frames();
    test_too_quick();
    test_phase_errors();
    test_register_extremes();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
